// ===== sv/iof_pkg.sv =====
// Shared types, opcode constants and width helpers for the immediate-op fusion block.
// No dependencies; compiled first.
package iof_pkg;

    localparam int REG_BITS_DEF = 8;
    localparam int Q_DEPTH      = 4;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_AND = 4'd2;
    localparam logic [3:0] OP_OR  = 4'd3;
    localparam logic [3:0] OP_XOR = 4'd4;
    localparam logic [3:0] OP_SHL = 4'd5;
    localparam logic [3:0] OP_SHR = 4'd6;
    localparam logic [3:0] OP_SAR = 4'd7;

    localparam logic [1:0] WC_8  = 2'd0;
    localparam logic [1:0] WC_16 = 2'd1;
    localparam logic [1:0] WC_32 = 2'd2;
    localparam logic [1:0] WC_64 = 2'd3;

    typedef struct packed {
        logic        is_reg_imm;
        logic [7:0]  dest_reg;
        logic [1:0]  width_code;
        logic [3:0]  op_code;
        logic [63:0] immediate;
        logic [63:0] payload;
        logic        last;
    } t_word;

    function automatic logic [63:0] width_mask(input logic [1:0] wc);
        logic [63:0] m;
        case (wc)
            WC_8:    m = 64'h0000_0000_0000_00FF;
            WC_16:   m = 64'h0000_0000_0000_FFFF;
            WC_32:   m = 64'h0000_0000_FFFF_FFFF;
            WC_64:   m = 64'hFFFF_FFFF_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [6:0] shift_max(input logic [1:0] wc);
        logic [6:0] s;
        case (wc)
            WC_8:    s = 7'd7;
            WC_16:   s = 7'd15;
            WC_32:   s = 7'd31;
            WC_64:   s = 7'd63;
            default: s = 7'd63;
        endcase
        return s;
    endfunction

endpackage

// ===== sv/iof_intf.sv =====
// Handshake interfaces for the instruction input channel and the result channel.
// No dependencies beyond plain logic types.
interface iof_in_if;
    logic        valid;
    logic        ready;
    logic        is_reg_imm;
    logic [7:0]  dest_reg;
    logic [1:0]  width_code;
    logic [3:0]  op_code;
    logic [63:0] immediate;
    logic [63:0] payload;
    logic        last;

    modport source (
        output valid, is_reg_imm, dest_reg, width_code, op_code, immediate, payload, last,
        input  ready
    );
    modport sink (
        input  valid, is_reg_imm, dest_reg, width_code, op_code, immediate, payload, last,
        output ready
    );
endinterface

interface iof_out_if;
    logic        valid;
    logic        ready;
    logic        out_is_reg_imm;
    logic [7:0]  out_dest_reg;
    logic [1:0]  out_width_code;
    logic [3:0]  out_op_code;
    logic [63:0] out_immediate;
    logic [63:0] out_payload;
    logic        out_last;

    modport source (
        output valid, out_is_reg_imm, out_dest_reg, out_width_code, out_op_code,
               out_immediate, out_payload, out_last,
        input  ready
    );
    modport sink (
        input  valid, out_is_reg_imm, out_dest_reg, out_width_code, out_op_code,
               out_immediate, out_payload, out_last,
        output ready
    );
endinterface

// ===== sv/immediate_op_fusion.sv =====
// Immediate-op fusion top level: pending instruction register, merge logic, result queue.
// Depends on iof_pkg and the iof_in_if / iof_out_if interfaces.
//
// Usage:
//   i_ins carries one instruction word per valid/ready handshake. o_res carries emitted
//   words. A register-immediate word that folds into the held one emits nothing; a word
//   that does not fold emits the held one; a pass-through word emits the held one (if
//   any) and then itself; a word marked last flushes, its final result has out_last set.
//   Each accepted word yields zero, one or two results.
//   Timing: a result is visible on o_res in the cycle after the word that causes it is
//   accepted, when the queue ahead of it is empty.
//   Throughput: one word per cycle while each word yields at most one result and o_res
//   is not stalled; a word yielding two results needs two queue entries. The four-entry
//   result queue sets this: i_ins.ready is high while at least two entries are free.
//   Stall: when o_res.ready is low, results wait in the queue and input is still taken
//   until fewer than two entries remain free.
//   Reset: synchronous, active low; clears the held instruction and empties the queue.
module immediate_op_fusion #(
    parameter int REG_BITS = iof_pkg::REG_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    iof_in_if.sink   i_ins,
    iof_out_if.source o_res
);
    import iof_pkg::*;

    localparam int DW = (REG_BITS < 8) ? REG_BITS : 8;
    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    // pending instruction
    logic          r_pv;
    logic [DW-1:0] r_preg;
    logic [1:0]    r_pwidth;
    logic [3:0]    r_pop;
    logic [63:0]   r_pimm;
    logic [63:0]   r_ppay;

    // result queue
    t_word         r_q [Q_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic          acc;
    logic          rd;
    logic [DW-1:0] in_reg;
    logic          merged;
    logic [3:0]    m_op;
    logic [63:0]   m_imm;
    logic          emit_old;
    logic          emit_new;
    t_word         w_old;
    t_word         w_new;
    logic [CW-1:0] nwr;
    logic          n_pv;

    assign in_reg = i_ins.dest_reg[DW-1:0];
    assign acc    = i_ins.valid && i_ins.ready;
    assign rd     = o_res.valid && o_res.ready;

    assign i_ins.ready = (r_count <= CW'(Q_DEPTH - 2));

    always_comb begin
        logic        p_arith;
        logic        n_arith;
        logic        can;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] ar;
        logic [64:0] sh_sum;
        logic [63:0] smax;
        a       = r_pimm;
        b       = i_ins.immediate;
        p_arith = (r_pop == OP_ADD) || (r_pop == OP_SUB);
        n_arith = (i_ins.op_code == OP_ADD) || (i_ins.op_code == OP_SUB);
        sh_sum  = {1'b0, a} + {1'b0, b};
        smax    = 64'(shift_max(r_pwidth));
        case ({r_pop == OP_ADD, i_ins.op_code == OP_ADD})
            2'b11:   ar = a + b;
            2'b10:   ar = a - b;
            2'b01:   ar = b - a;
            default: ar = 64'd0 - (a + b);
        endcase
        can   = 1'b0;
        m_op  = r_pop;
        m_imm = r_pimm;
        if (p_arith && n_arith) begin
            can   = 1'b1;
            m_op  = OP_ADD;
            m_imm = ar & width_mask(r_pwidth);
        end else if (r_pop == i_ins.op_code) begin
            case (r_pop)
                OP_AND: begin
                    can   = 1'b1;
                    m_imm = (a & b) & width_mask(r_pwidth);
                end
                OP_OR: begin
                    can   = 1'b1;
                    m_imm = (a | b) & width_mask(r_pwidth);
                end
                OP_XOR: begin
                    can   = 1'b1;
                    m_imm = (a ^ b) & width_mask(r_pwidth);
                end
                OP_SHL, OP_SHR, OP_SAR: begin
                    can   = 1'b1;
                    m_imm = (sh_sum[64] || sh_sum[63:0] > smax) ? smax : sh_sum[63:0];
                end
                default: can = 1'b0;
            endcase
        end
        merged = i_ins.is_reg_imm && r_pv && (r_preg == in_reg)
                 && (r_pwidth == i_ins.width_code) && can;
    end

    always_comb begin
        emit_old = r_pv && !merged;
        emit_new = merged ? i_ins.last : (i_ins.is_reg_imm ? i_ins.last : 1'b1);
        nwr      = CW'(emit_old) + CW'(emit_new);
        n_pv     = i_ins.is_reg_imm && !i_ins.last;

        w_old.is_reg_imm = 1'b1;
        w_old.dest_reg   = 8'(r_preg);
        w_old.width_code = r_pwidth;
        w_old.op_code    = r_pop;
        w_old.immediate  = r_pimm;
        w_old.payload    = r_ppay;
        w_old.last       = 1'b0;

        if (merged) begin
            w_new.is_reg_imm = 1'b1;
            w_new.dest_reg   = 8'(r_preg);
            w_new.width_code = r_pwidth;
            w_new.op_code    = m_op;
            w_new.immediate  = m_imm;
            w_new.payload    = r_ppay;
        end else begin
            w_new.is_reg_imm = i_ins.is_reg_imm;
            w_new.dest_reg   = 8'(in_reg);
            w_new.width_code = i_ins.width_code;
            w_new.op_code    = i_ins.op_code;
            w_new.immediate  = i_ins.immediate;
            w_new.payload    = i_ins.payload;
        end
        w_new.last = i_ins.last;
    end

    // hold or replace the pending instruction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (acc) begin
            r_pv <= n_pv;
        end
        if (acc && i_ins.is_reg_imm) begin
            if (merged) begin
                r_pop  <= m_op;
                r_pimm <= m_imm;
            end else begin
                r_preg   <= in_reg;
                r_pwidth <= i_ins.width_code;
                r_pop    <= i_ins.op_code;
                r_pimm   <= i_ins.immediate;
                r_ppay   <= i_ins.payload;
            end
        end
    end

    // result queue: up to two writes, one read per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (acc) begin
                r_wr_ptr <= r_wr_ptr + PW'(nwr);
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= r_count + (acc ? nwr : CW'(0)) - CW'(rd);
        end
        if (acc) begin
            if (emit_old) begin
                r_q[r_wr_ptr] <= w_old;
            end
            if (emit_new) begin
                r_q[r_wr_ptr + PW'(emit_old)] <= w_new;
            end
        end
    end

    assign o_res.valid          = (r_count != '0);
    assign o_res.out_is_reg_imm = r_q[r_rd_ptr].is_reg_imm;
    assign o_res.out_dest_reg   = r_q[r_rd_ptr].dest_reg;
    assign o_res.out_width_code = r_q[r_rd_ptr].width_code;
    assign o_res.out_op_code    = r_q[r_rd_ptr].op_code;
    assign o_res.out_immediate  = r_q[r_rd_ptr].immediate;
    assign o_res.out_payload    = r_q[r_rd_ptr].payload;
    assign o_res.out_last       = r_q[r_rd_ptr].last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(Q_DEPTH))
        else $error("result queue overfilled");

    a_last_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_ins.last |=> !r_pv && r_count != '0)
        else $error("last word did not flush pending instruction");

    a_pass_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && !i_ins.is_reg_imm |=> !r_pv && r_count != '0)
        else $error("pass-through word left a pending instruction or emitted nothing");

    a_no_emit_keeps_pv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && nwr == '0 |=> r_pv)
        else $error("silent merge dropped the pending instruction");

endmodule

// ===== verif/testbench.sv =====
// Testbench for immediate_op_fusion: drives instruction words, predicts fused results
// in a scoreboard class and checks every result word. Depends on iof_pkg, iof_in_if/iof_out_if.
`timescale 1ns / 100ps

module testbench;
    import iof_pkg::*;

    localparam int          RAND_WORDS  = 1000;
    localparam int          HOLD_AT     = 300;
    localparam int          HOLD_CYCLES = 400;
    localparam int          CYCLE_LIMIT = 800000;
    localparam logic [7:0]  REG_MASK    = 8'((1 << REG_BITS_DEF) - 1);
    localparam logic [3:0]  OP_PLAIN_LO = 4'd8;
    localparam logic [3:0]  OP_PLAIN_HI = 4'd15;

    class fusion_scoreboard;
        bit          pend_valid = 1'b0;
        logic [7:0]  pend_reg   = '0;
        logic [1:0]  pend_width = '0;
        logic [3:0]  pend_op    = '0;
        logic [63:0] pend_imm   = '0;
        logic [63:0] pend_pay   = '0;
        t_word       fused_q[$];
        int          errors     = 0;
        int          n_checked  = 0;

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        function logic [63:0] lane_mask(logic [1:0] wc);
            return (wc == WC_64) ? '1 : (64'd1 << (8 << wc)) - 64'd1;
        endfunction

        function bit fold(logic [3:0] op, logic [63:0] imm);
            logic [63:0] acc;
            logic [64:0] sum;
            logic [64:0] cap;
            bit          p_arith;
            bit          n_arith;
            p_arith = (pend_op == OP_ADD) || (pend_op == OP_SUB);
            n_arith = (op == OP_ADD) || (op == OP_SUB);
            if (p_arith && n_arith) begin
                acc = (pend_op == OP_ADD) ? pend_imm : -pend_imm;
                acc = (op == OP_ADD) ? acc + imm : acc - imm;
                pend_op  = OP_ADD;
                pend_imm = acc & lane_mask(pend_width);
                return 1'b1;
            end
            if (pend_op != op) return 1'b0;
            case (op)
                OP_AND: pend_imm = pend_imm & imm & lane_mask(pend_width);
                OP_OR:  pend_imm = (pend_imm | imm) & lane_mask(pend_width);
                OP_XOR: pend_imm = (pend_imm ^ imm) & lane_mask(pend_width);
                OP_SHL, OP_SHR, OP_SAR: begin
                    cap = 65'(8 << pend_width) - 65'd1;
                    sum = {1'b0, pend_imm} + {1'b0, imm};
                    if (sum > cap) sum = cap;
                    pend_imm = sum[63:0];
                end
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function void flush();
            t_word r;
            if (!pend_valid) return;
            r = '{1'b1, pend_reg, pend_width, pend_op, pend_imm, pend_pay, 1'b0};
            fused_q.push_back(r);
            pend_valid = 1'b0;
        endfunction

        function void note_word(t_word w);
            int    n0;
            bit    merged;
            t_word r;
            n0 = fused_q.size();
            w.dest_reg = w.dest_reg & REG_MASK;
            if (w.is_reg_imm) begin
                merged = pend_valid && pend_reg == w.dest_reg &&
                         pend_width == w.width_code && fold(w.op_code, w.immediate);
                if (!merged) begin
                    flush();
                    pend_valid = 1'b1;
                    pend_reg   = w.dest_reg;
                    pend_width = w.width_code;
                    pend_op    = w.op_code;
                    pend_imm   = w.immediate;
                    pend_pay   = w.payload;
                end
                if (w.last) flush();
            end else begin
                flush();
                r = w;
                r.last = 1'b0;
                fused_q.push_back(r);
            end
            if (w.last && fused_q.size() > n0) begin
                r = fused_q.pop_back();
                r.last = 1'b1;
                fused_q.push_back(r);
            end
        endfunction

        task check_result(t_word got);
            t_word want;
            if (fused_q.size() == 0) begin
                report($sformatf("result %0d arrived with none outstanding", n_checked));
            end else begin
                want = fused_q.pop_front();
                if (got.is_reg_imm !== want.is_reg_imm)
                    report($sformatf("result %0d is_reg_imm %h want %h", n_checked,
                                     got.is_reg_imm, want.is_reg_imm));
                if (got.dest_reg !== want.dest_reg)
                    report($sformatf("result %0d dest_reg %h want %h", n_checked,
                                     got.dest_reg, want.dest_reg));
                if (got.width_code !== want.width_code)
                    report($sformatf("result %0d width_code %h want %h", n_checked,
                                     got.width_code, want.width_code));
                if (got.op_code !== want.op_code)
                    report($sformatf("result %0d op_code %h want %h", n_checked,
                                     got.op_code, want.op_code));
                if (got.immediate !== want.immediate)
                    report($sformatf("result %0d immediate %h want %h", n_checked,
                                     got.immediate, want.immediate));
                if (got.payload !== want.payload)
                    report($sformatf("result %0d payload %h want %h", n_checked,
                                     got.payload, want.payload));
                if (got.last !== want.last)
                    report($sformatf("result %0d last %h want %h", n_checked,
                                     got.last, want.last));
            end
            n_checked++;
        endtask

        function int outstanding();
            return fused_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycles   = 0;
    int   words_in = 0;
    bit   calm     = 1'b0;

    iof_in_if  ins_if ();
    iof_out_if res_if ();

    fusion_scoreboard sb = new();

    immediate_op_fusion u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ins   (ins_if),
        .o_res   (res_if)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_word mk(bit isri, logic [7:0] rg, logic [1:0] wc, logic [3:0] op,
                                 logic [63:0] imm, logic [63:0] pay, bit lst);
        t_word w;
        w.is_reg_imm = isri;
        w.dest_reg   = rg;
        w.width_code = wc;
        w.op_code    = op;
        w.immediate  = imm;
        w.payload    = pay;
        w.last       = lst;
        return w;
    endfunction

    task automatic send_word(t_word w, int gap);
        if (gap > 0) begin
            ins_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ins_if.valid      <= 1'b1;
        ins_if.is_reg_imm <= w.is_reg_imm;
        ins_if.dest_reg   <= w.dest_reg;
        ins_if.width_code <= w.width_code;
        ins_if.op_code    <= w.op_code;
        ins_if.immediate  <= w.immediate;
        ins_if.payload    <= w.payload;
        ins_if.last       <= w.last;
        do @(posedge i_clk); while (!ins_if.ready);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && ins_if.valid && ins_if.ready) begin
            sb.note_word('{ins_if.is_reg_imm, ins_if.dest_reg, ins_if.width_code,
                           ins_if.op_code, ins_if.immediate, ins_if.payload, ins_if.last});
            words_in <= words_in + 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_result('{res_if.out_is_reg_imm, res_if.out_dest_reg,
                              res_if.out_width_code, res_if.out_op_code,
                              res_if.out_immediate, res_if.out_payload, res_if.out_last});
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result sink: random stalls, one long hold-off once the input has run a while
    initial begin
        int  stall;
        int  run;
        bit  held;
        stall = 0;
        run   = 0;
        held  = 1'b0;
        res_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (!held && words_in >= HOLD_AT) begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                stall--;
                res_if.ready <= 1'b0;
            end else if (calm || run > 0) begin
                if (run > 0) run--;
                res_if.ready <= 1'b1;
            end else begin
                run   = $urandom_range(0, 12);
                stall = rand_gap();
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        t_word       dir_q[$];
        t_word       w;
        logic [3:0]  fam;
        logic [7:0]  seq_reg;
        logic [1:0]  seq_wc;
        int          seq_left;
        int          n;

        ins_if.valid      <= 1'b0;
        ins_if.is_reg_imm <= 1'b0;
        ins_if.dest_reg   <= '0;
        ins_if.width_code <= '0;
        ins_if.op_code    <= '0;
        ins_if.immediate  <= '0;
        ins_if.payload    <= '0;
        ins_if.last       <= 1'b0;
        i_rst_n           <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // arithmetic folding with wrap and masking
        dir_q.push_back(mk(1'b1, 8'd1, WC_8, OP_ADD, 64'hFF, 64'h11, 1'b0));
        dir_q.push_back(mk(1'b1, 8'd1, WC_8, OP_SUB, 64'h1, 64'h12, 1'b0));
        dir_q.push_back(mk(1'b1, 8'd1, WC_8, OP_SUB, '1, 64'h13, 1'b0));
        // logic ops, uncombined immediate stays unmasked
        dir_q.push_back(mk(1'b1, 8'd1, WC_8, OP_AND, '1, 64'h14, 1'b0));
        dir_q.push_back(mk(1'b1, 8'd1, WC_8, OP_AND, 64'hF0, 64'h15, 1'b0));
        dir_q.push_back(mk(1'b1, 8'd2, WC_16, OP_OR, 64'h0, 64'h16, 1'b0));
        dir_q.push_back(mk(1'b1, 8'd2, WC_16, OP_OR, 64'hFFFF_0000_1234, 64'h17, 1'b0));
        dir_q.push_back(mk(1'b1, 8'd3, WC_32, OP_XOR, 64'hDEAD_BEEF_CAFE_F00D, 64'h18,
                           1'b0));
        dir_q.push_back(mk(1'b1, 8'd3, WC_32, OP_XOR, 64'h1234_5678_9ABC_DEF0, 64'h19,
                           1'b0));
        // shift clamps: to width-1, and on 64-bit overflow
        dir_q.push_back(mk(1'b1, 8'd3, WC_32, OP_SHL, 64'd20, 64'h1A, 1'b0));
        dir_q.push_back(mk(1'b1, 8'd3, WC_32, OP_SHL, 64'd20, 64'h1B, 1'b0));
        dir_q.push_back(mk(1'b1, 8'd4, WC_64, OP_SHR, '1, 64'h1C, 1'b0));
        dir_q.push_back(mk(1'b1, 8'd4, WC_64, OP_SHR, 64'd2, 64'h1D, 1'b0));
        dir_q.push_back(mk(1'b1, 8'd4, WC_64, OP_SAR, 64'd3, 64'h1E, 1'b0));
        // last with a merge
        dir_q.push_back(mk(1'b1, 8'd4, WC_64, OP_SAR, 64'd4, 64'h1F, 1'b1));
        // mismatched width, then mismatched register
        dir_q.push_back(mk(1'b1, 8'd255, WC_8, OP_SUB, 64'd5, 64'h20, 1'b0));
        dir_q.push_back(mk(1'b1, 8'd255, WC_16, OP_SUB, 64'd5, 64'h21, 1'b0));
        dir_q.push_back(mk(1'b1, 8'd254, WC_16, OP_SUB, 64'd5, 64'h22, 1'b0));
        // uncombinable ops never fold
        dir_q.push_back(mk(1'b1, 8'd254, WC_16, OP_PLAIN_LO, 64'd7, 64'h23, 1'b0));
        dir_q.push_back(mk(1'b1, 8'd254, WC_16, OP_PLAIN_LO, 64'd7, 64'h24, 1'b0));
        // pass-through behind a held word, then alone with last
        dir_q.push_back(mk(1'b0, 8'd255, WC_64, OP_PLAIN_HI, '1, '1, 1'b0));
        dir_q.push_back(mk(1'b0, 8'd0, WC_8, OP_ADD, '0, '0, 1'b1));
        // last without a merge: two results
        dir_q.push_back(mk(1'b1, 8'd0, WC_8, OP_PLAIN_HI, '0, '0, 1'b0));
        dir_q.push_back(mk(1'b1, 8'd0, WC_8, OP_PLAIN_LO, '1, '1, 1'b1));
        foreach (dir_q[i]) send_word(dir_q[i], rand_gap());

        seq_left = 0;
        fam      = OP_ADD;
        seq_reg  = '0;
        seq_wc   = WC_8;
        for (n = 0; n < RAND_WORDS; n++) begin
            if (n == 600) begin
                ins_if.valid <= 1'b0;
                do @(posedge i_clk); while (sb.outstanding() > 0);
            end
            calm = (n >= 700 && n < 800);
            if (seq_left == 0) begin
                fam      = 4'($urandom_range(OP_ADD, OP_SAR));
                seq_reg  = 8'($urandom_range(0, 255));
                seq_wc   = 2'($urandom_range(WC_8, WC_64));
                seq_left = $urandom_range(1, 8);
            end
            seq_left--;
            if ($urandom_range(0, 99) < 8) begin
                w = mk(1'b0, 8'($urandom_range(0, 255)), 2'($urandom_range(WC_8, WC_64)),
                       4'($urandom_range(OP_ADD, OP_PLAIN_HI)), rand64(), rand64(), 1'b0);
            end else begin
                w = mk(1'b1, seq_reg, seq_wc, fam, rand64(), rand64(), 1'b0);
                if ($urandom_range(0, 99) < 10) w.dest_reg = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 99) < 8)
                    w.width_code = 2'($urandom_range(WC_8, WC_64));
                if (fam == OP_ADD || fam == OP_SUB)
                    w.op_code = $urandom_range(0, 1) ? OP_SUB : OP_ADD;
                if ($urandom_range(0, 99) < 20)
                    w.op_code = 4'($urandom_range(OP_ADD, OP_PLAIN_HI));
                if (w.op_code inside {OP_SHL, OP_SHR, OP_SAR} && $urandom_range(0, 99) < 75)
                    w.immediate = 64'($urandom_range(0, 9 << w.width_code));
            end
            w.last = ($urandom_range(0, 99) < 4) || (n == RAND_WORDS - 1);
            send_word(w, calm ? 0 : rand_gap());
        end
        ins_if.valid <= 1'b0;

        do @(posedge i_clk); while (sb.outstanding() > 0);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
